// File: hw/rtl/satl_pkg.sv
// Shared types and constants for the set-associative cache tag lookup.
// Holds the sequencer state encoding, cache geometry, generator constants and bus widths.
// No dependencies.
`default_nettype none

package satl_pkg;

  // Fixed field widths of the streaming channels
  localparam int ADDR_W    = 32;
  localparam int CNT_VAL_W = 32;
  localparam int OUT_W     = 72;

  // Cache geometry; every size is a power of two, so the address splits into fields
  localparam int WAYS        = 4;
  localparam int LINE_BYTES  = 32;
  localparam int CACHE_BYTES = 65536;
  localparam int SETS        = CACHE_BYTES / (WAYS * LINE_BYTES);
  localparam int OFF_W       = $clog2(LINE_BYTES);
  localparam int IDX_W       = $clog2(SETS);
  localparam int WAY_W       = $clog2(WAYS);
  localparam int TAG_W       = ADDR_W - OFF_W - IDX_W;
  localparam int MEM_AW      = IDX_W + WAY_W;
  localparam int MEM_DEPTH   = 1 << MEM_AW;

  // Multiply-with-carry generator constants and seeds
  localparam logic [15:0] MWC_Z_MUL   = 16'd36969;
  localparam logic [15:0] MWC_W_MUL   = 16'd18000;
  localparam logic [31:0] GEN_Z_RESET = 32'h0508_0902;
  localparam logic [31:0] GEN_W_RESET = 32'hABAB_AB55;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    S_CLR  = 7'b000_0001,
    S_IDLE = 7'b000_0010,
    S_RD   = 7'b000_0100,
    S_CMP  = 7'b000_1000,
    S_MZ   = 7'b001_0000,
    S_MW   = 7'b010_0000,
    S_FILL = 7'b100_0000
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/set_assoc_cache_tag_lookup.sv
// Operation: each way is checked in turn, the tag and valid memories read in S_RD and
// compared in S_CMP; a miss in every way steps the generator and fills a victim way.
// One item at a time; the next address transfer can be taken once the result is
// loaded into the output register, which waits while that register is still full.
// Reset: synchronous, active low; a clearing pass then writes every valid bit, one per
// cycle (MEM_DEPTH bits, 2048), with in_tready low. Depends on satl_pkg.
`default_nettype none

module set_assoc_cache_tag_lookup
  import satl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [ADDR_W-1:0] in_tdata,   // [31:0] address
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata   // [0] hit, [2:1] way, [34:3] hit_total,
                                             // [66:35] miss_total, [71:67] zero
);

  // Control state
  state_t               state_r, state_nxt;
  logic [MEM_AW-1:0]    clr_r, clr_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic                 done_r, done_nxt;
  logic [31:0]          gen_z_r, gen_z_nxt;
  logic [31:0]          gen_w_r, gen_w_nxt;
  logic [CNT_VAL_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [CNT_VAL_W-1:0] miss_cnt_r, miss_cnt_nxt;

  // Payload
  logic [IDX_W-1:0]     set_r, set_nxt;
  logic [TAG_W-1:0]     tag_r, tag_nxt;
  logic [WAY_W-1:0]     way_r, way_nxt;
  logic                 hit_r, hit_nxt;
  logic [OUT_W-1:0]     out_tdata_r, out_tdata_nxt;

  // Memories and their ports
  logic [TAG_W-1:0]     tag_mem [MEM_DEPTH];
  logic                 vld_mem [MEM_DEPTH];
  logic [TAG_W-1:0]     tag_rd_r;
  logic                 vld_rd_r;
  logic [MEM_AW-1:0]    rd_addr;
  logic [MEM_AW-1:0]    fill_addr;
  logic                 fill_we;
  logic                 clr_we;

  // Shared datapath signals
  logic [ADDR_W-OFF_W-1:0] line_no;
  logic [31:0]          mul_in;
  logic [15:0]          mul_k;
  logic [31:0]          mul_prod;
  logic [31:0]          mul_res;
  logic [WAY_W-1:0]     vic_way;
  logic                 tag_match;
  logic                 last_way;
  logic                 out_free;
  logic [1:0]           way_field;

  assign in_tready  = (state_r == S_IDLE) && !done_r;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Drop the line offset; set index and tag follow
  assign line_no = in_tdata[ADDR_W-1:OFF_W];

  // Shared 16x16 multiplier for both generator halves
  assign mul_in   = (state_r == S_MZ) ? gen_z_r : gen_w_r;
  assign mul_k    = (state_r == S_MZ) ? MWC_Z_MUL : MWC_W_MUL;
  assign mul_prod = {16'h0000, mul_in[15:0]} * {16'h0000, mul_k};
  assign mul_res  = mul_prod + {16'h0000, mul_in[31:16]};

  // Generator output is (z << 16) + w; its low bits are those of w
  assign vic_way   = gen_w_r[WAY_W-1:0];
  assign tag_match = vld_rd_r && (tag_rd_r == tag_r);
  assign last_way  = (way_r == WAY_W'(WAYS - 1));
  assign out_free  = !out_tvalid_r || out_tready;
  assign way_field = 2'(way_r);

  assign rd_addr   = {set_r, way_r};
  assign fill_addr = {set_r, vic_way};
  assign fill_we   = (state_r == S_FILL);
  assign clr_we    = (state_r == S_CLR);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    out_tvalid_nxt = out_tvalid_r;
    done_nxt       = done_r;
    gen_z_nxt      = gen_z_r;
    gen_w_nxt      = gen_w_r;
    hit_cnt_nxt    = hit_cnt_r;
    miss_cnt_nxt   = miss_cnt_r;
    set_nxt        = set_r;
    tag_nxt        = tag_r;
    way_nxt        = way_r;
    hit_nxt        = hit_r;
    out_tdata_nxt  = out_tdata_r;

    // Drop the result once the downstream side takes it
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + MEM_AW'(1);
        if (clr_r == {MEM_AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        // Hold a finished result until the output register frees up
        if (done_r) begin
          if (out_free) begin
            if (hit_r) begin
              hit_cnt_nxt = (hit_cnt_r == '1) ? hit_cnt_r : hit_cnt_r + CNT_VAL_W'(1);
            end else begin
              miss_cnt_nxt = (miss_cnt_r == '1) ? miss_cnt_r : miss_cnt_r + CNT_VAL_W'(1);
            end
            out_tdata_nxt  = {5'b0, miss_cnt_nxt, hit_cnt_nxt, way_field, hit_r};
            out_tvalid_nxt = 1'b1;
            done_nxt       = 1'b0;
          end
        end else if (in_tvalid) begin
          set_nxt   = line_no[IDX_W-1:0];
          tag_nxt   = line_no[IDX_W +: TAG_W];
          way_nxt   = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (tag_match) begin
          hit_nxt   = 1'b1;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else if (last_way) begin
          state_nxt = S_MZ;
        end else begin
          way_nxt   = way_r + WAY_W'(1);
          state_nxt = S_RD;
        end
      end
      S_MZ: begin
        gen_z_nxt = mul_res;
        state_nxt = S_MW;
      end
      S_MW: begin
        gen_w_nxt = mul_res;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        way_nxt   = vic_way;
        hit_nxt   = 1'b0;
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
      done_r       <= 1'b0;
      gen_z_r      <= GEN_Z_RESET;
      gen_w_r      <= GEN_W_RESET;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      done_r       <= done_nxt;
      gen_z_r      <= gen_z_nxt;
      gen_w_r      <= gen_w_nxt;
      hit_cnt_r    <= hit_cnt_nxt;
      miss_cnt_r   <= miss_cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    set_r       <= set_nxt;
    tag_r       <= tag_nxt;
    way_r       <= way_nxt;
    hit_r       <= hit_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // Tag store: written on fill, read registered
  always_ff @(posedge clk) begin
    if (fill_we) begin
      tag_mem[fill_addr] <= tag_r;
    end
    tag_rd_r <= tag_mem[rd_addr];
  end

  // Valid store: cleared after reset, set on fill, read registered
  always_ff @(posedge clk) begin
    if (clr_we) begin
      vld_mem[clr_r] <= 1'b0;
    end else if (fill_we) begin
      vld_mem[fill_addr] <= 1'b1;
    end
    vld_rd_r <= vld_mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: tb/set_assoc_cache_tag_lookup_tb.sv
// Self-checking testbench for the set-associative cache tag lookup.
// Predicts hit, way and both running counters per address and checks each result transfer.
// Depends on satl_pkg and set_assoc_cache_tag_lookup.
`default_nettype none

module set_assoc_cache_tag_lookup_tb
  import satl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_BITS = 5;
  localparam int SET_BITS  = 9;
  localparam int TAG_LEN   = ADDR_W - LINE_BITS - SET_BITS;
  localparam int NUM_SETS  = 1 << SET_BITS;
  localparam int NUM_WAYS  = 4;
  localparam int HOT_SETS  = 6;
  localparam int HOT_TAGS  = 6;
  localparam int RANDOM_ACCESSES = 1850;

  typedef struct {
    logic        hit;
    logic [1:0]  way;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } lookup_result_t;

  // Tracks tag store, replacement generator and counters; holds pending lookup results
  class cache_lookup_predictor;
    logic [TAG_LEN-1:0]  tag_mem [NUM_SETS][NUM_WAYS];
    bit                  line_valid [NUM_SETS][NUM_WAYS];
    logic [31:0]         mwc_z;
    logic [31:0]         mwc_w;
    logic [31:0]         hits;
    logic [31:0]         misses;
    lookup_result_t      expected_lookups[$];
    int unsigned         fail_count;

    function void clear();
      foreach (line_valid[s, w]) line_valid[s][w] = 1'b0;
      mwc_z      = GEN_Z_RESET;
      mwc_w      = GEN_W_RESET;
      hits       = '0;
      misses     = '0;
      fail_count = 0;
      expected_lookups.delete();
    endfunction

    function void note_access(logic [31:0] addr);
      logic [SET_BITS-1:0] set_idx;
      logic [TAG_LEN-1:0]  tag;
      logic [31:0]         rnd;
      lookup_result_t      r;
      set_idx = addr[LINE_BITS +: SET_BITS];
      tag     = addr[ADDR_W-1 -: TAG_LEN];
      r.hit   = 1'b0;
      r.way   = '0;
      // lowest matching valid way wins
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
        if (line_valid[set_idx][w] && tag_mem[set_idx][w] == tag) begin
          r.hit = 1'b1;
          r.way = 2'(w);
        end
      end
      if (r.hit) begin
        if (hits != 32'hFFFF_FFFF) hits = hits + 32'd1;
      end else begin
        // step the multiply-with-carry generator only on a miss
        mwc_z = 32'(MWC_Z_MUL) * {16'h0, mwc_z[15:0]} + {16'h0, mwc_z[31:16]};
        mwc_w = 32'(MWC_W_MUL) * {16'h0, mwc_w[15:0]} + {16'h0, mwc_w[31:16]};
        rnd   = {mwc_z[15:0], 16'h0} + mwc_w;
        r.way = rnd[1:0];
        tag_mem[set_idx][r.way]    = tag;
        line_valid[set_idx][r.way] = 1'b1;
        if (misses != 32'hFFFF_FFFF) misses = misses + 32'd1;
      end
      r.hit_total  = hits;
      r.miss_total = misses;
      expected_lookups.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      fail_count++;
    endtask

    task check_result(logic [OUT_W-1:0] data);
      lookup_result_t want;
      if (expected_lookups.size() == 0) begin
        report_mismatch($sformatf("result 0x%h with no pending access", data));
      end else begin
        want = expected_lookups.pop_front();
        if (data[0] !== want.hit)
          report_mismatch($sformatf("hit got %b want %b", data[0], want.hit));
        if (data[2:1] !== want.way)
          report_mismatch($sformatf("way got %0d want %0d", data[2:1], want.way));
        if (data[34:3] !== want.hit_total)
          report_mismatch($sformatf("hit_total got %0d want %0d",
                                    data[34:3], want.hit_total));
        if (data[66:35] !== want.miss_total)
          report_mismatch($sformatf("miss_total got %0d want %0d",
                                    data[66:35], want.miss_total));
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [ADDR_W-1:0] in_tdata;   // [31:0] address
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;  // [0] hit, [2:1] way, [34:3] hit_total, [66:35] miss_total

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  logic [SET_BITS-1:0] hot_sets [HOT_SETS];
  logic [TAG_LEN-1:0]  hot_tags [HOT_SETS][HOT_TAGS];
  logic [31:0]         last_addr = '0;

  cache_lookup_predictor lookups;

  set_assoc_cache_tag_lookup i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) lookups.check_result(out_tdata);
  end

  // Offer one address, idling first at random; returns just after a falling edge
  task automatic send_access(input logic [31:0] addr);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
    lookups.note_access(addr);
    @(negedge clk);
  endtask

  // Draw a fresh working set: a few sets, each with more tags than ways
  function automatic void refresh_working_set();
    foreach (hot_sets[s]) begin
      hot_sets[s] = SET_BITS'($urandom);
      foreach (hot_tags[s][t]) hot_tags[s][t] = TAG_LEN'($urandom);
    end
  endfunction

  // Mostly reuse of the working set, some same-line repeats, some wild addresses
  function automatic logic [31:0] pick_address();
    int unsigned roll;
    int unsigned s;
    logic [31:0] a;
    roll = $urandom_range(99);
    s    = $urandom_range(HOT_SETS - 1);
    if (roll < 65)
      a = {hot_tags[s][$urandom_range(HOT_TAGS - 1)], hot_sets[s], LINE_BITS'($urandom)};
    else if (roll < 80)
      a = {last_addr[31:LINE_BITS], LINE_BITS'($urandom)};
    else
      a = $urandom;
    last_addr = a;
    return a;
  endfunction

  initial begin
    int unsigned idle_by_phase  [4] = '{0, 72, 0, 18};
    int unsigned stall_by_phase [4] = '{0, 0, 72, 18};
    logic [31:0] directed [$];

    in_tvalid = 1'b0;
    in_tdata  = '0;
    rst_n     = 1'b0;
    lookups   = new();
    lookups.clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, same-line hits, alternating bits, eviction in one set
    directed = '{32'h0000_0000, 32'h0000_0000, 32'h0000_001F, 32'hFFFF_FFFF,
                 32'hFFFF_FFE0, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000,
                 32'h0000_3FFF};
    for (int t = 1; t <= 6; t++) directed.push_back({18'(t), 9'h0D, 5'h00});
    for (int t = 1; t <= 6; t++) directed.push_back({18'(t), 9'h0D, 5'h1F});
    foreach (directed[i]) send_access(directed[i]);

    // Random traffic under each idling and stalling pattern
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      refresh_working_set();
      repeat (RANDOM_ACCESSES / 4) send_access(pick_address());
    end
    in_tvalid <= 1'b0;

    // Drain, then keep watching for stray results
    while (lookups.expected_lookups.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (lookups.expected_lookups.size() != 0)
      lookups.report_mismatch($sformatf("%0d results never arrived",
                                        lookups.expected_lookups.size()));
    if (lookups.fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// File: set_assoc_cache_tag_lookup.f
hw/rtl/satl_pkg.sv
hw/rtl/set_assoc_cache_tag_lookup.sv
tb/set_assoc_cache_tag_lookup_tb.sv
